// ===== rtl/mps_pkg.sv =====
// ----------------------------------------------------------------------------
// mps_pkg
// Shared types and codes for the merge point scoreboard.
// ----------------------------------------------------------------------------
`default_nettype none

package mps_pkg;

   // Write state held for one resource in the store.
   localparam logic [1:0] ST_NONE  = 2'd0;
   localparam logic [1:0] ST_MAIN  = 2'd1;
   localparam logic [1:0] ST_STAGE = 2'd2;

   // Request operation codes.
   localparam logic OP_DESC  = 1'b0;
   localparam logic OP_BUILD = 1'b1;

   // Source kinds.
   localparam logic [1:0] SRC_ANY   = 2'd0;
   localparam logic [1:0] SRC_OWNED = 2'd1;
   localparam logic [1:0] SRC_EMPTY = 2'd2;
   localparam logic [1:0] SRC_OTHER = 2'd3;

   // Operator kinds.
   localparam logic [1:0] OPK_AND   = 2'd0;
   localparam logic [1:0] OPK_OR    = 2'd1;
   localparam logic [1:0] OPK_NOT   = 2'd2;
   localparam logic [1:0] OPK_OTHER = 2'd3;

   // Access kinds.
   localparam logic [1:0] ACC_RW    = 2'd0;
   localparam logic [1:0] ACC_READ  = 2'd1;
   localparam logic [1:0] ACC_WRITE = 2'd2;
   localparam logic [1:0] ACC_OTHER = 2'd3;

   localparam int TAG_W   = 32;
   localparam int ENTRY_W = TAG_W + 2;

   // One buffered access descriptor.
   typedef struct packed {
      logic [1:0]       src;
      logic [1:0]       opk;
      logic [1:0]       acc;
      logic             wild;
      logic [TAG_W-1:0] id;
   } desc_type;

   localparam int DESC_W = $bits(desc_type);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_DECIDE,
      S_REP_RD,
      S_REP_LD,
      S_FINISH
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/mps_ram.sv =====
// ----------------------------------------------------------------------------
// mps_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/merge_point_scoreboard.sv =====
// ----------------------------------------------------------------------------
// merge_point_scoreboard
// Places merge points in an ordered list of tasks from their access requests.
// ----------------------------------------------------------------------------
// Each descriptor request carries one access descriptor; the one marked last
// produces one response for the task; a build request clears store and groups.
// The resource store is a RAM filled in order, so a fill count marks its valid
// entries and a merge clears it by resetting that count. One compare unit
// walks the filled entries until a match or the last one; a wildcard, an "or"
// operator or an empty store skips the walk. After a merge on an active task,
// each buffered descriptor is replayed through the same unit. The block takes
// one request at a time; a finished response waits in an output register.
`default_nettype none

module merge_point_scoreboard
   import mps_pkg::*;
#(
   parameter int STORE_ENTRIES   = 64,
   parameter int MAX_DESCRIPTORS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_op,
   input  wire logic [1:0]  req_source_kind,
   input  wire logic [1:0]  req_operator_kind,
   input  wire logic [1:0]  req_access_kind,
   input  wire logic [31:0] req_resource_id,
   input  wire logic        req_is_wildcard,
   input  wire logic        req_task_active,
   input  wire logic        req_last_descriptor,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_merge_before,
   output logic             rsp_starts_group,
   output logic [7:0]       rsp_group_index,
   output logic [15:0]      rsp_group_task_count,
   output logic             rsp_store_overflow
);

   localparam int SW = (STORE_ENTRIES > 1) ? $clog2(STORE_ENTRIES) : 1;
   localparam int FW = $clog2(STORE_ENTRIES + 1);
   localparam int BW = (MAX_DESCRIPTORS > 1) ? $clog2(MAX_DESCRIPTORS) : 1;
   localparam int CW = $clog2(MAX_DESCRIPTORS + 1);
   localparam logic [FW-1:0] STORE_FULL = FW'(STORE_ENTRIES);
   localparam logic [CW-1:0] BUF_FULL   = CW'(MAX_DESCRIPTORS);

   state_type        state_ff, state_in;
   desc_type         cur_ff, cur_in;
   logic             act_ff, act_in;
   logic             last_ff, last_in;
   logic             replay_ff, replay_in;
   logic [SW-1:0]    idx_ff, idx_in;
   logic [1:0]       st_ff, st_in;
   logic             found_ff, found_in;
   logic [FW-1:0]    fill_ff, fill_in;
   logic [FW-1:0]    staged_ff, staged_in;
   logic             wc_ff, wc_in;
   logic             pending_ff, pending_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    rep_ff, rep_in;
   logic             dropped_ff, dropped_in;
   logic             ovf_ff, ovf_in;
   logic [7:0]       group_ff, group_in;
   logic [15:0]      gcount_ff, gcount_in;
   logic             open_ff, open_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             merge_out_ff, merge_out_in;
   logic             starts_out_ff, starts_out_in;
   logic             ovf_out_ff, ovf_out_in;
   logic [7:0]       group_out_ff, group_out_in;
   logic [15:0]      gcount_out_ff, gcount_out_in;

   // Store RAM ports.
   logic               st_we;
   logic [SW-1:0]      st_waddr;
   logic [ENTRY_W-1:0] st_wdata;
   logic [ENTRY_W-1:0] st_rdata;

   // Descriptor buffer ports.
   logic               bf_we;
   logic [DESC_W-1:0]  bf_rdata;

   // Decision terms for the current descriptor.
   logic       reads, writes, need, rec, any_staged, starts;
   logic [1:0] rec_val;
   desc_type   req_desc;

   assign req_desc.src  = req_source_kind;
   assign req_desc.opk  = req_operator_kind;
   assign req_desc.acc  = req_access_kind;
   assign req_desc.wild = req_is_wildcard;
   assign req_desc.id   = req_resource_id;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_merge_before     = merge_out_ff;
   assign rsp_starts_group     = starts_out_ff;
   assign rsp_group_index      = group_out_ff;
   assign rsp_group_task_count = gcount_out_ff;
   assign rsp_store_overflow   = ovf_out_ff;

   mps_ram #(.WIDTH(ENTRY_W), .DEPTH(STORE_ENTRIES), .AW(SW)) u_store (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_addr (idx_ff),
      .rd_data (st_rdata)
   );

   mps_ram #(.WIDTH(DESC_W), .DEPTH(MAX_DESCRIPTORS), .AW(BW)) u_buffer (
      .clock   (clock),
      .wr_en   (bf_we),
      .wr_addr (count_ff[BW-1:0]),
      .wr_data (req_desc),
      .rd_addr (rep_ff[BW-1:0]),
      .rd_data (bf_rdata)
   );

   // Descriptor evaluation rules.
   always_comb begin
      reads      = (cur_ff.acc == ACC_RW) || (cur_ff.acc == ACC_READ);
      writes     = act_ff && ((cur_ff.acc == ACC_RW) || (cur_ff.acc == ACC_WRITE));
      any_staged = wc_ff || (staged_ff != '0);
      need       = 1'b0;
      rec        = 1'b0;
      rec_val    = ST_MAIN;
      if (cur_ff.opk == OPK_OR) begin
         need = 1'b0;
      end else if ((cur_ff.src == SRC_ANY || cur_ff.src == SRC_OWNED) &&
                   cur_ff.opk != OPK_NOT) begin
         if (reads && (st_ff == ST_STAGE || wc_ff)) begin
            need = 1'b1;
         end else begin
            rec = writes;
         end
      end else if (cur_ff.src == SRC_EMPTY || cur_ff.opk == OPK_NOT) begin
         need    = reads && (st_ff == ST_STAGE || (cur_ff.wild && any_staged));
         rec     = writes;
         rec_val = ST_STAGE;
      end
   end

   // Sequencer: next state, store updates and response.
   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      act_in        = act_ff;
      last_in       = last_ff;
      replay_in     = replay_ff;
      idx_in        = idx_ff;
      st_in         = st_ff;
      found_in      = found_ff;
      fill_in       = fill_ff;
      staged_in     = staged_ff;
      wc_in         = wc_ff;
      pending_in    = pending_ff;
      count_in      = count_ff;
      rep_in        = rep_ff;
      dropped_in    = dropped_ff;
      ovf_in        = ovf_ff;
      group_in      = group_ff;
      gcount_in     = gcount_ff;
      open_in       = open_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      merge_out_in  = merge_out_ff;
      starts_out_in = starts_out_ff;
      ovf_out_in    = ovf_out_ff;
      group_out_in  = group_out_ff;
      gcount_out_in = gcount_out_ff;
      st_we         = 1'b0;
      st_waddr      = idx_ff;
      st_wdata      = {cur_ff.id, rec_val};
      bf_we         = 1'b0;
      starts        = pending_ff || !open_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_BUILD) begin
                  fill_in    = '0;
                  staged_in  = '0;
                  wc_in      = 1'b0;
                  pending_in = 1'b0;
                  count_in   = '0;
                  dropped_in = 1'b0;
                  ovf_in     = 1'b0;
                  group_in   = '0;
                  gcount_in  = '0;
                  open_in    = 1'b0;
               end else begin
                  cur_in    = req_desc;
                  act_in    = req_task_active;
                  last_in   = req_last_descriptor;
                  replay_in = 1'b0;
                  if (count_ff < BUF_FULL) begin
                     bf_we    = 1'b1;
                     count_in = count_ff + CW'(1);
                  end else begin
                     dropped_in = 1'b1;
                  end
                  state_in = S_EVAL;
               end
            end
         end

         // Start the lookup, or skip it where the store is not consulted.
         S_EVAL: begin
            idx_in   = '0;
            st_in    = ST_NONE;
            found_in = 1'b0;
            if (cur_ff.opk == OPK_OR || cur_ff.wild || fill_ff == '0) begin
               state_in = S_DECIDE;
            end else begin
               state_in = S_SCAN_RD;
            end
         end

         S_SCAN_RD: begin
            state_in = S_SCAN_CMP;
         end

         // Compare one store entry against the resource id.
         S_SCAN_CMP: begin
            if (st_rdata[ENTRY_W-1:2] == cur_ff.id) begin
               st_in    = st_rdata[1:0];
               found_in = 1'b1;
               state_in = S_DECIDE;
            end else if ({1'b0, idx_ff} + FW'(1) == fill_ff) begin
               state_in = S_DECIDE;
            end else begin
               idx_in   = idx_ff + SW'(1);
               state_in = S_SCAN_RD;
            end
         end

         // Record the write state, note whether a merge is needed, then go on to the next step.
         S_DECIDE: begin
            if (rec) begin
               if (cur_ff.wild) begin
                  if (rec_val == ST_STAGE) begin
                     wc_in = 1'b1;
                  end
               end else if (found_ff) begin
                  st_we = 1'b1;
                  if (st_ff == ST_STAGE && rec_val == ST_MAIN) begin
                     staged_in = staged_ff - FW'(1);
                  end else if (st_ff == ST_MAIN && rec_val == ST_STAGE) begin
                     staged_in = staged_ff + FW'(1);
                  end
               end else if (fill_ff < STORE_FULL) begin
                  st_we    = 1'b1;
                  st_waddr = fill_ff[SW-1:0];
                  fill_in  = fill_ff + FW'(1);
                  if (rec_val == ST_STAGE) begin
                     staged_in = staged_ff + FW'(1);
                  end
               end else begin
                  ovf_in = 1'b1;
               end
            end
            if (replay_ff) begin
               rep_in = rep_ff + CW'(1);
               if (rep_ff + CW'(1) == count_ff) begin
                  if (dropped_ff) begin
                     ovf_in = 1'b1;
                  end
                  state_in = S_FINISH;
               end else begin
                  state_in = S_REP_RD;
               end
            end else begin
               if (need) begin
                  pending_in = 1'b1;
               end
               if (!last_ff) begin
                  state_in = S_IDLE;
               end else if (pending_ff || need) begin
                  // Merge: clear the store and replay an active task.
                  pending_in = 1'b1;
                  fill_in    = '0;
                  staged_in  = '0;
                  wc_in      = 1'b0;
                  ovf_in     = 1'b0;
                  rep_in     = '0;
                  if (act_ff && count_ff != '0) begin
                     replay_in = 1'b1;
                     state_in  = S_REP_RD;
                  end else begin
                     if (act_ff && dropped_ff) begin
                        ovf_in = 1'b1;
                     end
                     state_in = S_FINISH;
                  end
               end else begin
                  state_in = S_FINISH;
               end
            end
         end

         S_REP_RD: begin
            state_in = S_REP_LD;
         end

         S_REP_LD: begin
            cur_in   = desc_type'(bf_rdata);
            state_in = S_EVAL;
         end

         // Update group state and load the response register.
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               group_in  = group_ff;
               gcount_in = gcount_ff;
               if (starts) begin
                  if (open_ff) begin
                     group_in = (group_ff != 8'hFF) ? group_ff + 8'd1 : group_ff;
                  end else begin
                     group_in = '0;
                  end
                  gcount_in = '0;
                  open_in   = 1'b1;
               end
               if (act_ff && gcount_in != 16'hFFFF) begin
                  gcount_in = gcount_in + 16'd1;
               end
               rsp_valid_in  = 1'b1;
               merge_out_in  = pending_ff;
               starts_out_in = starts;
               ovf_out_in    = ovf_ff;
               group_out_in  = group_in;
               gcount_out_in = gcount_in;
               pending_in    = 1'b0;
               count_in      = '0;
               dropped_in    = 1'b0;
               ovf_in        = 1'b0;
               replay_in     = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         replay_ff    <= 1'b0;
         fill_ff      <= '0;
         staged_ff    <= '0;
         wc_ff        <= 1'b0;
         pending_ff   <= 1'b0;
         count_ff     <= '0;
         rep_ff       <= '0;
         dropped_ff   <= 1'b0;
         ovf_ff       <= 1'b0;
         group_ff     <= '0;
         gcount_ff    <= '0;
         open_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         replay_ff    <= replay_in;
         fill_ff      <= fill_in;
         staged_ff    <= staged_in;
         wc_ff        <= wc_in;
         pending_ff   <= pending_in;
         count_ff     <= count_in;
         rep_ff       <= rep_in;
         dropped_ff   <= dropped_in;
         ovf_ff       <= ovf_in;
         group_ff     <= group_in;
         gcount_ff    <= gcount_in;
         open_ff      <= open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      act_ff        <= act_in;
      last_ff       <= last_in;
      idx_ff        <= idx_in;
      st_ff         <= st_in;
      found_ff      <= found_in;
      merge_out_ff  <= merge_out_in;
      starts_out_ff <= starts_out_in;
      ovf_out_ff    <= ovf_out_in;
      group_out_ff  <= group_out_in;
      gcount_out_ff <= gcount_out_in;
   end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the merge point scoreboard.
// ----------------------------------------------------------------------------
// Tasks are sent as streams of access requests with random gaps. The responses
// are taken with random stalls. A behavioral copy of the store, the descriptor
// buffer and the group counters predicts every response, and each response is
// compared field by field with the oldest prediction.
module tb;
   import mps_pkg::*;

   localparam int STORE_ENTRIES   = 64;
   localparam int MAX_DESCRIPTORS = 16;
   localparam int CYCLE_LIMIT     = 3000000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_op;
   logic [1:0]  req_source_kind;
   logic [1:0]  req_operator_kind;
   logic [1:0]  req_access_kind;
   logic [31:0] req_resource_id;
   logic        req_is_wildcard;
   logic        req_task_active;
   logic        req_last_descriptor;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_merge_before;
   logic        rsp_starts_group;
   logic [7:0]  rsp_group_index;
   logic [15:0] rsp_group_task_count;
   logic        rsp_store_overflow;

   merge_point_scoreboard dut (.*);

   typedef struct {
      logic        merge_before;
      logic        starts_group;
      logic [7:0]  group_index;
      logic [15:0] group_task_count;
      logic        store_overflow;
   } task_verdict_type;

   // Predicted scoreboard state.
   logic [31:0]    tag_copy [STORE_ENTRIES];
   logic [1:0]     state_copy [STORE_ENTRIES];
   logic           wild_staged_copy;
   logic           merge_pending_copy;
   desc_type       desc_copy [MAX_DESCRIPTORS];
   int             desc_fill;
   logic           desc_lost;
   logic           write_lost;
   int unsigned    group_num;
   int unsigned    group_actives;
   logic           group_live;

   task_verdict_type pending_verdicts[$];
   int          failures = 0;
   int unsigned cycle_count = 0;
   int          items_sent;
   int          rsp_stall;
   logic        idle_calm;
   logic [31:0] id_pool [8];

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL merge_point_scoreboard");
         $finish;
      end
   end

   function automatic void clear_resources();
      for (int i = 0; i < STORE_ENTRIES; i++) state_copy[i] = ST_NONE;
      wild_staged_copy = 1'b0;
   endfunction

   function automatic void clear_all();
      clear_resources();
      merge_pending_copy = 1'b0;
      desc_fill  = 0;
      desc_lost  = 1'b0;
      write_lost = 1'b0;
      group_num     = 0;
      group_actives = 0;
      group_live    = 1'b0;
   endfunction

   function automatic logic [1:0] find_state(logic [31:0] id);
      for (int i = 0; i < STORE_ENTRIES; i++)
         if (state_copy[i] != ST_NONE && tag_copy[i] == id) return state_copy[i];
      return ST_NONE;
   endfunction

   function automatic logic staged_anywhere();
      if (wild_staged_copy) return 1'b1;
      for (int i = 0; i < STORE_ENTRIES; i++)
         if (state_copy[i] == ST_STAGE) return 1'b1;
      return 1'b0;
   endfunction

   // Records a write state; a full store marks the task as overflowed.
   function automatic void note_write(logic [31:0] id, logic wild, logic [1:0] value);
      if (wild) begin
         if (value == ST_STAGE) wild_staged_copy = 1'b1;
         return;
      end
      for (int i = 0; i < STORE_ENTRIES; i++)
         if (state_copy[i] != ST_NONE && tag_copy[i] == id) begin
            state_copy[i] = value;
            return;
         end
      for (int i = 0; i < STORE_ENTRIES; i++)
         if (state_copy[i] == ST_NONE) begin
            tag_copy[i]   = id;
            state_copy[i] = value;
            return;
         end
      write_lost = 1'b1;
   endfunction

   // Returns 1 when the access needs a merge; records writes of active tasks.
   function automatic logic judge_access(desc_type d, logic act);
      logic [1:0] st;
      logic       reads;
      logic       writes;
      logic       need;
      reads  = (d.acc == ACC_RW || d.acc == ACC_READ);
      writes = act && (d.acc == ACC_RW || d.acc == ACC_WRITE);
      if (d.opk == OPK_OR) return 1'b0;
      st = d.wild ? ST_NONE : find_state(d.id);
      if ((d.src == SRC_ANY || d.src == SRC_OWNED) && d.opk != OPK_NOT) begin
         if (reads && (st == ST_STAGE || wild_staged_copy)) return 1'b1;
         if (writes) note_write(d.id, d.wild, ST_MAIN);
         return 1'b0;
      end
      if (d.src == SRC_EMPTY || d.opk == OPK_NOT) begin
         need = reads && (st == ST_STAGE || (d.wild && staged_anywhere()));
         if (writes) note_write(d.id, d.wild, ST_STAGE);
         return need;
      end
      return 1'b0;
   endfunction

   // Updates the predicted state for one accepted request.
   function automatic void predict_request(logic op, desc_type d, logic act, logic last);
      task_verdict_type v;
      if (op == OP_BUILD) begin
         clear_all();
         return;
      end
      if (desc_fill < MAX_DESCRIPTORS) begin
         desc_copy[desc_fill] = d;
         desc_fill++;
      end else
         desc_lost = 1'b1;
      if (judge_access(d, act)) merge_pending_copy = 1'b1;
      if (!last) return;

      v.merge_before = merge_pending_copy;
      if (v.merge_before) begin
         clear_resources();
         write_lost = 1'b0;
         if (act) begin
            for (int i = 0; i < desc_fill; i++) void'(judge_access(desc_copy[i], 1'b1));
            if (desc_lost) write_lost = 1'b1;
         end
      end
      v.starts_group = v.merge_before || !group_live;
      if (v.starts_group) begin
         if (group_live) group_num = (group_num < 255) ? group_num + 1 : 255;
         else group_num = 0;
         group_actives = 0;
         group_live = 1'b1;
      end
      if (act && group_actives < 65535) group_actives++;
      v.group_index      = group_num[7:0];
      v.group_task_count = group_actives[15:0];
      v.store_overflow   = write_lost;
      pending_verdicts.push_back(v);
      merge_pending_copy = 1'b0;
      desc_fill  = 0;
      desc_lost  = 1'b0;
      write_lost = 1'b0;
   endfunction

   function automatic int draw_wait();
      return idle_calm ? 0 : $urandom_range(0, 12);
   endfunction

   // Response side: random stalls and comparison with the oldest prediction.
   always @(posedge clock) begin
      task_verdict_type v;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_verdicts.size() == 0) begin
               $error("response with no task waiting");
               failures++;
            end else begin
               v = pending_verdicts.pop_front();
               if (rsp_merge_before !== v.merge_before) begin
                  $error("merge_before: expected %0d, got %0d",
                         v.merge_before, rsp_merge_before);
                  failures++;
               end
               if (rsp_starts_group !== v.starts_group) begin
                  $error("starts_group: expected %0d, got %0d",
                         v.starts_group, rsp_starts_group);
                  failures++;
               end
               if (rsp_group_index !== v.group_index) begin
                  $error("group_index: expected %0d, got %0d",
                         v.group_index, rsp_group_index);
                  failures++;
               end
               if (rsp_group_task_count !== v.group_task_count) begin
                  $error("group_task_count: expected %0d, got %0d",
                         v.group_task_count, rsp_group_task_count);
                  failures++;
               end
               if (rsp_store_overflow !== v.store_overflow) begin
                  $error("store_overflow: expected %0d, got %0d",
                         v.store_overflow, rsp_store_overflow);
                  failures++;
               end
            end
            rsp_stall = draw_wait();
         end
         if (rsp_stall > 0) begin
            rsp_ready <= 1'b0;
            rsp_stall--;
         end else
            rsp_ready <= 1'b1;
      end
   end

   // Sends one request and waits until it is accepted; valid stays high after.
   task automatic send_request(logic op, logic [1:0] src, logic [1:0] opk,
                               logic [1:0] acc, logic [31:0] id, logic wild,
                               logic act, logic last);
      desc_type d;
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_op              <= op;
      req_source_kind     <= src;
      req_operator_kind   <= opk;
      req_access_kind     <= acc;
      req_resource_id     <= id;
      req_is_wildcard     <= wild;
      req_task_active     <= act;
      req_last_descriptor <= last;
      do @(posedge clock); while (!req_ready);
      d.src = src; d.opk = opk; d.acc = acc; d.wild = wild; d.id = id;
      predict_request(op, d, act, last);
      items_sent++;
   endtask

   task automatic begin_build();
      send_request(OP_BUILD, 2'($urandom), 2'($urandom), 2'($urandom), $urandom,
                   1'($urandom), 1'($urandom), 1'($urandom));
   endtask

   // A staged write followed by a read of it on the very first task.
   task automatic test_first_task_merge();
      send_request(OP_DESC, SRC_EMPTY, OPK_AND, ACC_WRITE, 32'h0, 1'b0, 1'b1, 1'b0);
      send_request(OP_DESC, SRC_ANY, OPK_AND, ACC_READ, 32'h0, 1'b0, 1'b1, 1'b1);
   endtask

   // Every source and operator kind, access kinds in turn, some wildcards.
   task automatic test_kind_sweep();
      for (int s = 0; s < 4; s++)
         for (int o = 0; o < 4; o++)
            send_request(OP_DESC, s[1:0], o[1:0], 2'(s + o), 32'hFFFF_FFFF,
                         (o == 2), 1'b1, (o == 3));
      send_request(OP_DESC, SRC_EMPTY, OPK_NOT, ACC_RW, 32'h0, 1'b1, 1'b0, 1'b1);
      send_request(OP_DESC, SRC_OWNED, OPK_AND, ACC_READ, 32'h0, 1'b1, 1'b0, 1'b1);
   endtask

   // One active task writes more distinct resources than the store holds.
   task automatic test_store_full();
      begin_build();
      for (int i = 0; i < STORE_ENTRIES + 4; i++)
         send_request(OP_DESC, SRC_OWNED, OPK_AND, ACC_WRITE, 32'h8000_0000 + i,
                      1'b0, 1'b1, i == STORE_ENTRIES + 3);
   endtask

   // A task longer than the descriptor buffer that needs a merge and replay.
   task automatic test_descriptor_excess();
      begin_build();
      send_request(OP_DESC, SRC_EMPTY, OPK_AND, ACC_WRITE, 32'h55, 1'b0, 1'b1, 1'b1);
      for (int i = 0; i < MAX_DESCRIPTORS + 4; i++)
         send_request(OP_DESC, SRC_ANY, OPK_AND, (i == 18) ? ACC_READ : ACC_WRITE,
                      (i == 18) ? 32'h55 : 32'h100 + i, 1'b0, 1'b1,
                      i == MAX_DESCRIPTORS + 3);
   endtask

   // Enough merges in one build to saturate the group index.
   task automatic test_group_saturation();
      begin_build();
      for (int i = 0; i < 262; i++) begin
         send_request(OP_DESC, SRC_EMPTY, OPK_NOT, ACC_WRITE, 32'h7, 1'b0,
                      1'b1, 1'b0);
         send_request(OP_DESC, SRC_OWNED, OPK_AND, ACC_RW, 32'h7, 1'b0,
                      i[0], 1'b1);
      end
   endtask

   // Random tasks over a small pool of resources, with rare new builds.
   task automatic test_random_tasks(int goal);
      int          len;
      logic        act;
      logic [31:0] id;
      while (items_sent < goal) begin
         if ($urandom_range(0, 19) == 0) idle_calm = ~idle_calm;
         if ($urandom_range(0, 60) == 0) begin
            begin_build();
            continue;
         end
         len = ($urandom_range(0, 15) == 0) ? $urandom_range(14, 20)
                                            : $urandom_range(1, 6);
         act = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < len; i++) begin
            id = ($urandom_range(0, 9) == 0) ? $urandom : id_pool[$urandom_range(0, 7)];
            send_request(OP_DESC, 2'($urandom), 2'($urandom), 2'($urandom), id,
                         ($urandom_range(0, 7) == 0), act, i == len - 1);
         end
      end
   endtask

   // Test sequence.
   initial begin
      items_sent  = 0;
      idle_calm   = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_op      = OP_DESC;
      req_source_kind     = SRC_ANY;
      req_operator_kind   = OPK_AND;
      req_access_kind     = ACC_RW;
      req_resource_id     = '0;
      req_is_wildcard     = 1'b0;
      req_task_active     = 1'b0;
      req_last_descriptor = 1'b0;
      clear_all();
      id_pool[0] = 32'h0;
      id_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < 8; i++) id_pool[i] = $urandom;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_first_task_merge();
      test_kind_sweep();
      test_store_full();
      test_descriptor_excess();
      test_group_saturation();
      begin_build();
      test_random_tasks(1250);
      req_valid <= 1'b0;

      // Drain the responses, then allow for a slow replay to finish.
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (3000) @(posedge clock);
      if (failures == 0)
         $display("PASS merge_point_scoreboard");
      else
         $display("FAIL merge_point_scoreboard");
      $finish;
   end
endmodule

// ===== files.f =====
rtl/mps_pkg.sv
rtl/mps_ram.sv
rtl/merge_point_scoreboard.sv
tb/sv/tb.sv
